[src/alfl_pkg.sv]
// shared types for the array linked list with free chain
// no dependencies; used by alfl_mem and array_linked_list_free_list_top
package alfl_pkg;

    typedef enum logic [2:0] {
        OP_PUSH    = 3'd0,
        OP_DELETE  = 3'd1,
        OP_SEARCH  = 3'd2,
        OP_FIRST   = 3'd3,
        OP_REVERSE = 3'd4
    } t_opcode;

    typedef struct packed {
        logic rd_en;
        logic wr_item_en;
        logic wr_link_en;
    } t_mem_ctl;

endpackage

[src/alfl_mem.sv]
// item and link storage with one write port and one registered read port
// untouched entries at or above the fill count read their reset link (index plus one)
// depends on alfl_pkg
module alfl_mem #(
    parameter int CAPACITY  = 16,
    parameter int ITEM_BITS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  alfl_pkg::t_mem_ctl                 i_ctl,
    input  logic [$clog2(CAPACITY)-1:0]        i_rd_addr,
    input  logic [$clog2(CAPACITY)-1:0]        i_wr_addr,
    input  logic [ITEM_BITS-1:0]               i_wr_item,
    input  logic [$clog2(CAPACITY+1)-1:0]      i_wr_link,
    output logic [ITEM_BITS-1:0]               o_rd_item,
    output logic [$clog2(CAPACITY+1)-1:0]      o_rd_link
);

    localparam int IDXW = $clog2(CAPACITY+1);

    logic [ITEM_BITS-1:0] item_mem [CAPACITY];
    logic [IDXW-1:0]      link_mem [CAPACITY];

    logic [IDXW-1:0]      r_fill;
    logic [ITEM_BITS-1:0] r_rd_item;
    logic [IDXW-1:0]      r_rd_link;
    logic [IDXW-1:0]      r_rd_next;
    logic                 r_rd_fresh;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_item_en) begin
            item_mem[i_wr_addr] <= i_wr_item;
        end
        if (i_ctl.wr_link_en) begin
            link_mem[i_wr_addr] <= i_wr_link;
        end
        if (i_ctl.rd_en) begin
            r_rd_item  <= item_mem[i_rd_addr];
            r_rd_link  <= link_mem[i_rd_addr];
            r_rd_next  <= IDXW'(i_rd_addr) + IDXW'(1);
            r_rd_fresh <= IDXW'(i_rd_addr) >= r_fill;
        end
    end

    // fill count marks the first entry whose link was never written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_ctl.wr_link_en && IDXW'(i_wr_addr) == r_fill) begin
            r_fill <= r_fill + IDXW'(1);
        end
    end

    assign o_rd_item = r_rd_item;
    assign o_rd_link = r_rd_fresh ? r_rd_next : r_rd_link;

endmodule

[src/array_linked_list_free_list_top.sv]
// Singly linked list held in a CAPACITY-entry array, with unused entries kept on a free chain.
// Each request gives one result. Delete, search and reverse walk the list through the single
// read port of the entry memory, which the walk sequencer steps through one entry per cycle;
// a delete that finds its match then passes through an unlink state that returns the entry
// to the free chain. A new request is taken once the sequencer is idle, even while the previous
// result still waits on the output.
// No clearing pass is needed after reset. Depends on alfl_pkg and alfl_mem.
module array_linked_list_free_list_top #(
    parameter int CAPACITY  = 16,
    parameter int ITEM_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_opcode,
    input  logic [7:0] i_item_value,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_success,
    output logic [7:0] o_first_item,
    output logic       o_is_empty,
    output logic       o_is_full
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int IDXW = $clog2(CAPACITY+1);
    localparam logic [IDXW-1:0] NIL = IDXW'(CAPACITY);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_DISPATCH = 7'b0000010,
        ST_PUSH     = 7'b0000100,
        ST_WALK     = 7'b0001000,
        ST_UNLINK   = 7'b0010000,
        ST_FIN_RD   = 7'b0100000,
        ST_FIN      = 7'b1000000
    } t_state;

    t_state             r_state, n_state;
    alfl_pkg::t_opcode  r_op;
    logic [ITEM_BITS-1:0] r_x, x_in;
    logic [IDXW-1:0]    r_head, n_head;
    logic [IDXW-1:0]    r_free_head, n_free_head;
    logic [IDXW-1:0]    r_cur, n_cur;
    logic [IDXW-1:0]    r_prev, n_prev;
    logic               r_ok, n_ok;

    alfl_pkg::t_mem_ctl   mem_ctl;
    logic [AW-1:0]        rd_addr, wr_addr;
    logic [IDXW-1:0]      wr_link, rd_link;
    logic [ITEM_BITS-1:0] rd_item;
    logic                 hit;
    logic [7:0]           head_item;
    logic                 out_load;

    alfl_mem #(
        .CAPACITY  (CAPACITY),
        .ITEM_BITS (ITEM_BITS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_item (r_x),
        .i_wr_link (wr_link),
        .o_rd_item (rd_item),
        .o_rd_link (rd_link)
    );

    assign o_ready = (r_state == ST_IDLE);
    assign hit     = (rd_item == r_x);

    always_comb begin
        for (int i = 0; i < ITEM_BITS; i++) begin
            x_in[i] = (i < 8) ? i_item_value[i % 8] : 1'b0;
        end
        for (int i = 0; i < 8; i++) begin
            head_item[i] = (i < ITEM_BITS) ? rd_item[i % ITEM_BITS] : 1'b0;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_free_head = r_free_head;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_ok        = r_ok;
        mem_ctl     = '0;
        rd_addr     = '0;
        wr_addr     = '0;
        wr_link     = '0;
        out_load    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (r_op)
                    alfl_pkg::OP_PUSH: begin
                        if (r_free_head == NIL) begin
                            n_ok    = 1'b0;
                            n_state = ST_FIN_RD;
                        end else begin
                            mem_ctl.rd_en = 1'b1;
                            rd_addr       = r_free_head[AW-1:0];
                            n_state       = ST_PUSH;
                        end
                    end
                    alfl_pkg::OP_DELETE, alfl_pkg::OP_SEARCH, alfl_pkg::OP_REVERSE: begin
                        if (r_head == NIL) begin
                            n_ok    = (r_op == alfl_pkg::OP_REVERSE);
                            n_state = ST_FIN_RD;
                        end else begin
                            mem_ctl.rd_en = 1'b1;
                            rd_addr       = r_head[AW-1:0];
                            n_cur         = r_head;
                            n_prev        = NIL;
                            n_state       = ST_WALK;
                        end
                    end
                    alfl_pkg::OP_FIRST: begin
                        n_ok    = 1'b1;
                        n_state = ST_FIN_RD;
                    end
                    default: begin
                        n_ok    = 1'b0;
                        n_state = ST_FIN_RD;
                    end
                endcase
            end
            ST_PUSH: begin
                mem_ctl.wr_item_en = 1'b1;
                mem_ctl.wr_link_en = 1'b1;
                wr_addr            = r_free_head[AW-1:0];
                wr_link            = r_head;
                n_free_head        = rd_link;
                n_head             = r_free_head;
                n_ok               = 1'b1;
                n_state            = ST_FIN_RD;
            end
            ST_WALK: begin
                if (r_op == alfl_pkg::OP_REVERSE) begin
                    mem_ctl.wr_link_en = 1'b1;
                    wr_addr            = r_cur[AW-1:0];
                    wr_link            = r_prev;
                    n_prev             = r_cur;
                    if (rd_link == NIL) begin
                        n_head  = r_cur;
                        n_ok    = 1'b1;
                        n_state = ST_FIN_RD;
                    end else begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = rd_link[AW-1:0];
                        n_cur         = rd_link;
                    end
                end else if (hit) begin
                    n_ok = 1'b1;
                    if (r_op == alfl_pkg::OP_DELETE) begin
                        if (r_prev == NIL) begin
                            n_head = rd_link;
                        end else begin
                            mem_ctl.wr_link_en = 1'b1;
                            wr_addr            = r_prev[AW-1:0];
                            wr_link            = rd_link;
                        end
                        n_state = ST_UNLINK;
                    end else begin
                        n_state = ST_FIN_RD;
                    end
                end else if (rd_link == NIL) begin
                    n_ok    = 1'b0;
                    n_state = ST_FIN_RD;
                end else begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = rd_link[AW-1:0];
                    n_prev        = r_cur;
                    n_cur         = rd_link;
                end
            end
            ST_UNLINK: begin
                mem_ctl.wr_link_en = 1'b1;
                wr_addr            = r_cur[AW-1:0];
                wr_link            = r_free_head;
                n_free_head        = r_cur;
                n_state            = ST_FIN_RD;
            end
            ST_FIN_RD: begin
                if (r_head != NIL) begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = r_head[AW-1:0];
                end
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!o_valid || i_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= NIL;
            r_free_head <= '0;
            o_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_free_head <= n_free_head;
            if (out_load) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_prev <= n_prev;
        r_ok   <= n_ok;
        if (i_valid && o_ready) begin
            r_op <= alfl_pkg::t_opcode'(i_opcode);
            r_x  <= x_in;
        end
        if (out_load) begin
            o_success    <= r_ok;
            o_first_item <= (r_head == NIL) ? 8'd0 : head_item;
            o_is_empty   <= (r_head == NIL);
            o_is_full    <= (r_free_head == NIL);
        end
    end

    a_push_takes_free_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_PUSH |=> r_head == $past(r_free_head))
        else $error("push did not link the free head entry");

    a_walk_not_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WALK |-> r_cur != NIL)
        else $error("walk on a null entry");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == ST_FIN))
        else $error("result raised outside the final step");

    a_empty_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_empty |-> o_first_item == 8'd0)
        else $error("empty list reports a head item");

endmodule
